>>> rtl/group_reassembly_buffer_core_assert.svh
// Assertion macros used by the checker of the reassembly buffer.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef GROUP_REASSEMBLY_BUFFER_CORE_ASSERT_SVH
`define GROUP_REASSEMBLY_BUFFER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reassembly buffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define GRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reassembly buffer check failed");

`endif

>>> rtl/grb_pkg.sv
// Shared types and constants of the group reassembly buffer.
// Used by the controller, the datapath, the top level and the checker.
package grb_pkg;

  // Result status codes.
  localparam logic [1:0] ST_EMIT = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Operations the controller asks the datapath to carry out.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DROP_BAD,
    OP_DROP_FULL,
    OP_SINGLE,
    OP_WRITE,
    OP_WRITE_DONE,
    OP_ALLOC
  } grb_op_t;

  typedef struct packed {
    logic    take;
    grb_op_t op;
    logic    emit;
  } grb_cmd_t;

  typedef struct packed {
    logic size_bad;
    logic hit;
    logic idx_bad_hit;
    logic rem_one;
    logic idx_bad_new;
    logic size_one;
    logic free_ok;
    logic out_free;
    logic emit_done;
  } grb_sts_t;

endpackage

>>> rtl/grb_if.sv
// Valid/ready channel interfaces for the requests and results of the buffer.
// Standalone; widths are set where the interfaces are instantiated.
interface grb_item_if #(
  parameter int IDW   = 16,
  parameter int SLOTW = 4,
  parameter int SIZEW = 5,
  parameter int PAYW  = 32
);
  logic             valid;
  logic             ready;
  logic [IDW-1:0]   group_id;
  logic [SLOTW-1:0] slot_index;
  logic [SIZEW-1:0] group_size;
  logic [PAYW-1:0]  payload;

  modport source(output valid, group_id, slot_index, group_size, payload, input ready);
  modport sink(input valid, group_id, slot_index, group_size, payload, output ready);
endinterface

interface grb_result_if #(
  parameter int IDW   = 16,
  parameter int SLOTW = 4,
  parameter int PAYW  = 32
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDW-1:0]   group_id_res;
  logic [SLOTW-1:0] slot_index_res;
  logic [PAYW-1:0]  payload_res;
  logic             last;

  modport source(output valid, status, group_id_res, slot_index_res, payload_res, last,
                 input ready);
  modport sink(input valid, status, group_id_res, slot_index_res, payload_res, last,
               output ready);
endinterface

>>> rtl/grb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependencies.
module grb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/grb_ctrl.sv
// Controller state machine of the reassembly buffer.
// Depends on grb_pkg for the command and status structs.
module grb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  grb_pkg::grb_sts_t  sts,
  output grb_pkg::grb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  grb_pkg::grb_op_t dec_op;
  logic             needs_out;

  assign item_ready = (state == S_IDLE);

  // Decide what the latched request does, from the table lookup.
  always_comb begin
    if (sts.size_bad || (sts.hit && sts.idx_bad_hit) || (!sts.hit && sts.idx_bad_new)) begin
      dec_op = grb_pkg::OP_DROP_BAD;
    end else if (sts.hit) begin
      dec_op = sts.rem_one ? grb_pkg::OP_WRITE_DONE : grb_pkg::OP_WRITE;
    end else if (sts.size_one) begin
      dec_op = grb_pkg::OP_SINGLE;
    end else if (!sts.free_ok) begin
      dec_op = grb_pkg::OP_DROP_FULL;
    end else begin
      dec_op = grb_pkg::OP_ALLOC;
    end
    needs_out = (dec_op == grb_pkg::OP_DROP_BAD) || (dec_op == grb_pkg::OP_DROP_FULL) ||
                (dec_op == grb_pkg::OP_SINGLE);
  end

  always_comb begin
    state_next = state;
    cmd.take   = item_valid && item_ready;
    cmd.op     = grb_pkg::OP_NONE;
    cmd.emit   = (state == S_EMIT);
    case (state)
      S_IDLE: begin
        if (cmd.take) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // A request that gives a single result waits for the output register.
        if (!needs_out || sts.out_free) begin
          cmd.op     = dec_op;
          state_next = (dec_op == grb_pkg::OP_WRITE_DONE) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/grb_dpath.sv
// Datapath of the reassembly buffer: request latch, group table, slot RAM, output register.
// Depends on grb_pkg and grb_ram.
module grb_dpath #(
  parameter int OPEN_GROUPS  = 8,
  parameter int MAX_SLOTS    = 16,
  parameter int ID_BITS      = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int SLOTW        = $clog2(MAX_SLOTS),
  parameter int SIZEW        = $clog2(MAX_SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  grb_pkg::grb_cmd_t       cmd,
  output grb_pkg::grb_sts_t       sts,
  input  logic [ID_BITS-1:0]      group_id,
  input  logic [SLOTW-1:0]        slot_index,
  input  logic [SIZEW-1:0]        group_size,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [1:0]              status,
  output logic [ID_BITS-1:0]      group_id_res,
  output logic [SLOTW-1:0]        slot_index_res,
  output logic [PAYLOAD_BITS-1:0] payload_res,
  output logic                    last
);

  localparam int ENTW = (OPEN_GROUPS > 1) ? $clog2(OPEN_GROUPS) : 1;
  localparam int AW   = ENTW + SLOTW;

  // Latched request.
  logic [ID_BITS-1:0]      it_id;
  logic [SLOTW-1:0]        it_idx;
  logic [SIZEW-1:0]        it_size;
  logic [PAYLOAD_BITS-1:0] it_pay;

  // Group table.
  logic [OPEN_GROUPS-1:0] ent_valid;
  logic [ID_BITS-1:0]     ent_id   [OPEN_GROUPS];
  logic [SIZEW-1:0]       ent_size [OPEN_GROUPS];
  logic [SIZEW-1:0]       ent_rem  [OPEN_GROUPS];
  logic [MAX_SLOTS-1:0]   ent_mask [OPEN_GROUPS];

  logic            hit;
  logic [ENTW-1:0] hit_idx;
  logic            free_ok;
  logic [ENTW-1:0] free_idx;
  logic [SIZEW-1:0] hit_size;
  logic [SIZEW-1:0] hit_rem;
  logic [MAX_SLOTS-1:0] slot_bit;

  // Emission state.
  logic [ENTW-1:0]      em_entry;
  logic [SIZEW-1:0]     em_size;
  logic [MAX_SLOTS-1:0] em_mask;
  logic [SIZEW-1:0]     rd_cnt;
  logic [SLOTW-1:0]     ld_cnt;
  logic                 rd_pend;
  logic                 emit_issue;
  logic                 emit_load;
  logic                 emit_last;
  logic                 drop_load;
  logic                 out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_id   <= group_id;
      it_idx  <= slot_index;
      it_size <= group_size;
      it_pay  <= payload;
    end
  end

  // Lowest matching valid entry and lowest free entry.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int e = OPEN_GROUPS - 1; e >= 0; e--) begin
      if (ent_valid[e] && (ent_id[e] == it_id)) begin
        hit     = 1'b1;
        hit_idx = ENTW'(e);
      end
      if (!ent_valid[e]) begin
        free_ok  = 1'b1;
        free_idx = ENTW'(e);
      end
    end
  end

  assign hit_size = ent_size[hit_idx];
  assign hit_rem  = ent_rem[hit_idx];
  assign slot_bit = MAX_SLOTS'(1) << it_idx;

  assign out_free   = !res_valid || res_ready;
  assign emit_load  = cmd.emit && rd_pend && out_free;
  assign emit_last  = (SIZEW'(ld_cnt) == (em_size - SIZEW'(1)));
  assign emit_issue = cmd.emit && (rd_cnt != em_size) && (!rd_pend || emit_load);
  assign drop_load  = (cmd.op == grb_pkg::OP_DROP_BAD) || (cmd.op == grb_pkg::OP_DROP_FULL) ||
                      (cmd.op == grb_pkg::OP_SINGLE);

  always_comb begin
    sts.size_bad    = (it_size == '0) || (it_size > SIZEW'(MAX_SLOTS));
    sts.hit         = hit;
    sts.idx_bad_hit = (SIZEW'(it_idx) >= hit_size);
    sts.rem_one     = (hit_rem == SIZEW'(1));
    sts.idx_bad_new = (SIZEW'(it_idx) >= it_size);
    sts.size_one    = (it_size == SIZEW'(1));
    sts.free_ok     = free_ok;
    sts.out_free    = out_free;
    sts.emit_done   = emit_load && emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else begin
      case (cmd.op)
        grb_pkg::OP_WRITE_DONE: ent_valid[hit_idx]  <= 1'b0;
        grb_pkg::OP_ALLOC:      ent_valid[free_idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      grb_pkg::OP_WRITE, grb_pkg::OP_WRITE_DONE: begin
        ent_rem[hit_idx]         <= hit_rem - SIZEW'(1);
        ent_mask[hit_idx][it_idx] <= 1'b1;
      end
      grb_pkg::OP_ALLOC: begin
        ent_id[free_idx]   <= it_id;
        ent_size[free_idx] <= it_size;
        ent_rem[free_idx]  <= it_size - SIZEW'(1);
        ent_mask[free_idx] <= slot_bit;
      end
      default: ;
    endcase
  end

  // Emission counters: rd_cnt runs one read ahead of ld_cnt.
  always_ff @(posedge clk) begin
    if (cmd.op == grb_pkg::OP_WRITE_DONE) begin
      em_entry <= hit_idx;
      em_size  <= hit_size;
      em_mask  <= ent_mask[hit_idx] | slot_bit;
      rd_cnt   <= '0;
      ld_cnt   <= '0;
    end else begin
      if (emit_issue) begin
        rd_cnt <= rd_cnt + SIZEW'(1);
      end
      if (emit_load) begin
        ld_cnt <= ld_cnt + SLOTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (cmd.op == grb_pkg::OP_WRITE_DONE) begin
      rd_pend <= 1'b0;
    end else if (emit_issue) begin
      rd_pend <= 1'b1;
    end else if (emit_load) begin
      rd_pend <= 1'b0;
    end
  end

  assign ram_we    = (cmd.op == grb_pkg::OP_WRITE) || (cmd.op == grb_pkg::OP_WRITE_DONE) ||
                     (cmd.op == grb_pkg::OP_ALLOC);
  assign ram_waddr = {((cmd.op == grb_pkg::OP_ALLOC) ? free_idx : hit_idx), it_idx};
  assign ram_raddr = {em_entry, rd_cnt[SLOTW-1:0]};

  grb_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(2 ** AW)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(it_pay),
    .re   (emit_issue),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (drop_load || emit_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drop_load) begin
      case (cmd.op)
        grb_pkg::OP_DROP_FULL: status <= grb_pkg::ST_FULL;
        grb_pkg::OP_DROP_BAD:  status <= grb_pkg::ST_BAD;
        default:               status <= grb_pkg::ST_EMIT;
      endcase
      group_id_res   <= it_id;
      slot_index_res <= (cmd.op == grb_pkg::OP_SINGLE) ? '0 : it_idx;
      payload_res    <= (cmd.op == grb_pkg::OP_SINGLE) ? it_pay : '0;
      last           <= 1'b1;
    end else if (emit_load) begin
      status         <= grb_pkg::ST_EMIT;
      group_id_res   <= it_id;
      slot_index_res <= ld_cnt;
      // A slot never written in this group reads as zero.
      payload_res    <= em_mask[ld_cnt] ? ram_rdata : '0;
      last           <= emit_last;
    end
  end

endmodule

>>> rtl/group_reassembly_buffer_core.sv
// Group reassembly buffer. Each request carries a group id, a slot index, the group size and
// a payload word. Requests of one group are collected in a table of OPEN_GROUPS open groups;
// when the last missing request of a group arrives, the whole group leaves as results in slot
// order, slot 0 first, with last set on the final slot. A slot written twice keeps the newer
// word and still counts, and a slot never written leaves with a zero word. A group of size one
// leaves at once without taking a table entry. A bad size or index gives one result with status
// 2, a new group with no free entry gives one result with status 1; both leave the table as it
// was. Each request is accepted in one step; a lookup step then checks it against the table and
// writes it into the slot RAM, waiting for the output register if it gives a single result. A
// request that completes a group then has its slots read from the slot RAM in order, one slot per
// cycle when the result side takes every result. A new request is accepted only after the previous
// one has left the lookup and emission steps, but a pending single result does not block it.
// Depends on grb_pkg, grb_if, grb_ctrl, grb_dpath and grb_ram.
module group_reassembly_buffer_core #(
  parameter int OPEN_GROUPS  = 8,
  parameter int MAX_SLOTS    = 16,
  parameter int ID_BITS      = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input logic          clk,
  input logic          rst,
  grb_item_if.sink     items,
  grb_result_if.source results
);

  localparam int SLOTW = $clog2(MAX_SLOTS);
  localparam int SIZEW = $clog2(MAX_SLOTS + 1);

  grb_pkg::grb_cmd_t cmd;
  grb_pkg::grb_sts_t sts;
  logic              item_ready;

  // The controller sequences accept, lookup and emission; it sees the table only as status.
  grb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(items.valid),
    .item_ready(item_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign items.ready = item_ready;

  // The datapath holds the request latch, the group table, the slot RAM and the output
  // register that decouples the result side from the table.
  grb_dpath #(
    .OPEN_GROUPS (OPEN_GROUPS),
    .MAX_SLOTS   (MAX_SLOTS),
    .ID_BITS     (ID_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .SLOTW       (SLOTW),
    .SIZEW       (SIZEW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .group_id      (items.group_id),
    .slot_index    (items.slot_index),
    .group_size    (items.group_size),
    .payload       (items.payload),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .status        (results.status),
    .group_id_res  (results.group_id_res),
    .slot_index_res(results.slot_index_res),
    .payload_res   (results.payload_res),
    .last          (results.last)
  );

endmodule

>>> rtl/grb_checker.sv
// Port-level checker of the reassembly buffer and its bind to the top level.
// Depends on grb_pkg and the assertion macro header.
`include "group_reassembly_buffer_core_assert.svh"

module grb_checker #(
  parameter int IDW  = 16,
  parameter int PAYW = 32
) (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_ready,
  input logic [1:0]      status,
  input logic [IDW-1:0]  group_id_res,
  input logic [PAYW-1:0] payload_res,
  input logic            last
);

  // A stalled result holds.
  `GRB_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
                   res_valid && $stable(status) && $stable(group_id_res) &&
                   $stable(payload_res) && $stable(last))

  // Only the three defined codes appear.
  `GRB_ASSERT_NOW(a_status_code, clk, rst, res_valid,
                  status == grb_pkg::ST_EMIT || status == grb_pkg::ST_FULL ||
                  status == grb_pkg::ST_BAD)

  // A dropped request gives exactly one result with a zero word.
  `GRB_ASSERT_NOW(a_drop_single, clk, rst, res_valid && status != grb_pkg::ST_EMIT,
                  last && payload_res == '0)

  // Only group elements come in runs.
  `GRB_ASSERT_NOW(a_run_is_emit, clk, rst, res_valid && !last, status == grb_pkg::ST_EMIT)

endmodule

bind group_reassembly_buffer_core grb_checker #(
  .IDW (ID_BITS),
  .PAYW(PAYLOAD_BITS)
) u_grb_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .status      (results.status),
  .group_id_res(results.group_id_res),
  .payload_res (results.payload_res),
  .last        (results.last)
);
